### hw/rtl/mt19937_pkg.sv
// Shared types, constants and the tempering function of the MT19937 generator.
// Used by the controller, the top level and the port checker.
`default_nettype none

package mt19937_pkg;

  localparam int STATE_DEPTH  = 624;
  localparam int SHIFT_OFFSET = 397;

  localparam int ADDR_W = $clog2(STATE_DEPTH);
  localparam int IDX_W  = $clog2(STATE_DEPTH + 1);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] FAR_START = ADDR_W'(SHIFT_OFFSET % STATE_DEPTH);
  localparam logic [IDX_W-1:0]  IDX_END   = IDX_W'(STATE_DEPTH);

  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;

  localparam logic ACT_RESEED = 1'b0;
  localparam logic ACT_DRAW   = 1'b1;

  localparam logic STAT_OK       = 1'b0;
  localparam logic STAT_UNSEEDED = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_TW_RD0,
    ST_TW_RDN,
    ST_TW_RDF,
    ST_TW_WR,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic        load;
    logic [31:0] value;
    logic        status;
  } result_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mt19937_state_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the generator state words; no dependencies.
`default_nettype none

module mt19937_state_ram #(
  parameter int DEPTH = 624,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mt19937_ctrl.sv
// Sequencer of the MT19937 generator: seeding walk, in-place twist and draw.
// Depends on mt19937_pkg; drives the state RAM through a mem_req_t struct.
`default_nettype none

module mt19937_ctrl import mt19937_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        action_i,
  input  wire logic [31:0] seed_value_i,
  input  wire logic        out_free_i,
  input  wire logic [31:0] rdata_i,
  output      mem_req_t    mem_req_o,
  output      result_t     result_o
);

  ctrl_state_e       state_q, state_d;
  logic [IDX_W-1:0]  idx_q;
  logic              seeded_q;
  logic              miss_q;
  logic [ADDR_W-1:0] k_q;
  logic [ADDR_W-1:0] far_q;
  logic [31:0]       prev_q;
  logic [31:0]       prod_q;
  logic [31:0]       cur_q;
  logic [31:0]       nxt_q;

  logic              accept;
  logic              k_last;
  logic [ADDR_W-1:0] k_inc;
  logic [ADDR_W-1:0] next_addr;
  logic [31:0]       seed_word;
  logic [31:0]       seed_mix;
  logic [31:0]       twist_y;
  logic [31:0]       twist_word;

  assign accept     = in_valid_i && !in_stall_o;
  assign k_last     = (k_q == LAST_ADDR);
  assign k_inc      = k_q + ADDR_W'(1);
  assign next_addr  = k_last ? '0 : k_inc;
  assign seed_word  = prod_q + 32'(k_q);
  assign seed_mix   = prev_q ^ (prev_q >> 30);
  assign twist_y    = {cur_q[31], nxt_q[30:0]};
  assign twist_word = rdata_i ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : 32'd0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_RESEED) begin
            state_d = ST_SEED_MUL;
          end else if (!seeded_q) begin
            state_d = ST_DRAW_OUT;
          end else if (idx_q >= IDX_END) begin
            state_d = ST_TW_RD0;
          end else begin
            state_d = ST_DRAW_RD;
          end
        end
      end
      ST_SEED_MUL: state_d = ST_SEED_WR;
      ST_SEED_WR:  state_d = k_last ? ST_IDLE : ST_SEED_MUL;
      ST_TW_RD0:   state_d = ST_TW_RDN;
      ST_TW_RDN:   state_d = ST_TW_RDF;
      ST_TW_RDF:   state_d = ST_TW_WR;
      ST_TW_WR:    state_d = k_last ? ST_DRAW_RD : ST_TW_RDN;
      ST_DRAW_RD:  state_d = ST_DRAW_OUT;
      ST_DRAW_OUT: state_d = out_free_i ? ST_IDLE : ST_DRAW_OUT;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o      = 1'b1;
    mem_req_o       = '0;
    result_o.load   = 1'b0;
    result_o.status = miss_q ? STAT_UNSEEDED : STAT_OK;
    result_o.value  = miss_q ? 32'd0 : temper(rdata_i);
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && action_i == ACT_RESEED) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = '0;
          mem_req_o.wdata = seed_value_i;
        end
      end
      ST_SEED_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = k_q;
        mem_req_o.wdata = seed_word;
      end
      ST_TW_RD0: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = '0;
      end
      ST_TW_RDN: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = next_addr;
      end
      ST_TW_RDF: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = far_q;
      end
      ST_TW_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = k_q;
        mem_req_o.wdata = twist_word;
      end
      ST_DRAW_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = idx_q[ADDR_W-1:0];
      end
      ST_DRAW_OUT: result_o.load = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= IDX_END;
      seeded_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SEED_WR && k_last) begin
        idx_q    <= IDX_END;
        seeded_q <= 1'b1;
      end
      if (state_q == ST_TW_WR && k_last) begin
        idx_q <= '0;
      end
      if (state_q == ST_DRAW_OUT && out_free_i && !miss_q) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      miss_q <= !seeded_q;
      if (action_i == ACT_RESEED) begin
        prev_q <= seed_value_i;
        k_q    <= ADDR_W'(1);
      end else begin
        k_q   <= '0;
        far_q <= FAR_START;
      end
    end
    unique case (state_q)
      ST_SEED_MUL: prod_q <= 32'(SEED_MULT * seed_mix);
      ST_SEED_WR: begin
        prev_q <= seed_word;
        k_q    <= k_inc;
      end
      ST_TW_RDN: begin
        if (k_q == '0) begin
          cur_q <= rdata_i;
        end
      end
      ST_TW_RDF: nxt_q <= rdata_i;
      ST_TW_WR: begin
        cur_q <= nxt_q;
        k_q   <= k_inc;
        far_q <= (far_q == LAST_ADDR) ? '0 : far_q + ADDR_W'(1);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/mt19937_generator.sv
// Top level of the MT19937 generator: state RAM, sequencer and output register.
// Depends on mt19937_pkg, mt19937_state_ram and mt19937_ctrl.
`default_nettype none

// A reseed transfer writes all 624 state words through a registered 32-bit
// multiplier and keeps the input stalled until the last word is written. A draw
// transfer does one RAM read and one output load before the next acceptance,
// and waits while the output is stalled. The first draw after a seed, and every
// 624th draw after that, first runs the twist over the single-read-port state
// RAM. A draw before any seed returns status 1 and value 0 without a RAM read.
// The output register lets the next transfer be accepted while a result still
// waits downstream.
module mt19937_generator import mt19937_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        action_i,
  input  wire logic [31:0] seed_value_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [31:0] random_value_o,
  output      logic        status_o
);

  mem_req_t    mem_req;
  result_t     result;
  logic [31:0] rdata;
  logic        out_free;
  logic        out_valid_q, out_valid_d;
  logic [31:0] random_value_q;
  logic        status_q;

  assign out_free = !out_valid_q || !out_stall_i;

  mt19937_state_ram #(
    .DEPTH(STATE_DEPTH),
    .WIDTH(32)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .re_i   (mem_req.re),
    .raddr_i(mem_req.raddr),
    .rdata_o(rdata)
  );

  mt19937_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .seed_value_i(seed_value_i),
    .out_free_i  (out_free),
    .rdata_i     (rdata),
    .mem_req_o   (mem_req),
    .result_o    (result)
  );

  always_comb begin
    if (result.load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.load) begin
      random_value_q <= result.value;
      status_q       <= result.status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = random_value_q;
  assign status_o       = status_q;

endmodule

`default_nettype wire

### hw/rtl/mt19937_checker.sv
// Port-level checker for the MT19937 generator and its bind to the top level.
// Depends on mt19937_pkg and the port list of mt19937_generator.
`default_nettype none

module mt19937_checker import mt19937_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        action_i,
  input wire logic [31:0] seed_value_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] random_value_o,
  input wire logic        status_o
);

  // A stalled result holds until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(random_value_o) && $stable(status_o))
    else $error("stalled result changed");

  // A stalled request holds until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(action_i) && $stable(seed_value_i))
    else $error("stalled request changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_UNSEEDED |-> random_value_o == 32'd0)
    else $error("unseeded draw returned a nonzero value");

  // Every accepted transfer keeps the sequencer busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // A new result is only produced by a busy sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

endmodule

bind mt19937_generator mt19937_checker u_checker (.*);

`default_nettype wire

### dv/mt19937_generator_test.sv
// Self-checking testbench for mt19937_generator: drives reseed and draw requests,
// predicts each drawn word from its own copy of the twister state and checks results.
// Depends on mt19937_pkg and the mt19937_generator RTL.
`timescale 1ns / 1ps

module mt19937_generator_test import mt19937_pkg::*;;

  typedef struct packed {
    logic        act;
    logic [31:0] seed;
  } gen_request_t;

  typedef struct packed {
    logic [31:0] value;
    logic        status;
  } draw_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = ACT_RESEED;
  logic [31:0] seed_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] random_value;
  logic        status;

  gen_request_t pending_requests[$];
  draw_result_t expected_draws[$];
  gen_request_t next_req;
  draw_result_t oldest_draw;

  logic [31:0] twister_words [STATE_DEPTH];
  int unsigned twister_pos = STATE_DEPTH;
  bit          twister_seeded = 1'b0;

  int unsigned total_items = 1;
  int unsigned sent_items = 0;
  int unsigned accepted_items = 0;
  int unsigned idle_phase = 0;
  int unsigned send_idle_pct [3] = '{19, 55, 0};
  int unsigned recv_idle_pct [3] = '{55, 19, 0};

  int unsigned reseed_count = 0;
  int unsigned draw_count = 0;
  int unsigned unseeded_count = 0;
  int unsigned twist_count = 0;
  int unsigned checked_count = 0;
  int unsigned failures = 0;

  mt19937_generator dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .action_i      (action),
    .seed_value_i  (seed_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .random_value_o(random_value),
    .status_o      (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void seed_state(input logic [31:0] seed);
    logic [31:0] prev;
    twister_words[0] = seed;
    for (int i = 1; i < STATE_DEPTH; i++) begin
      prev = twister_words[i-1];
      twister_words[i] = SEED_MULT * (prev ^ (prev >> 30)) + 32'(i);
    end
    twister_pos = STATE_DEPTH;
  endfunction

  function automatic void twist_state();
    logic [31:0] y;
    for (int k = 0; k < STATE_DEPTH; k++) begin
      y = {twister_words[k][31], twister_words[(k + 1) % STATE_DEPTH][30:0]};
      twister_words[k] = twister_words[(k + SHIFT_OFFSET) % STATE_DEPTH] ^ (y >> 1)
                         ^ (y[0] ? TWIST_MATRIX : 32'd0);
    end
    twister_pos = 0;
    twist_count++;
  endfunction

  function automatic logic [31:0] tempered_word(input logic [31:0] raw);
    logic [31:0] s1, s2, s3;
    s1 = raw ^ {11'd0, raw[31:11]};
    s2 = s1 ^ ({s1[24:0], 7'd0} & TEMPER_B);
    s3 = s2 ^ ({s2[16:0], 15'd0} & TEMPER_C);
    return s3 ^ {18'd0, s3[31:18]};
  endfunction

  // Updates the predicted state for one accepted request and queues the draw it yields.
  function automatic void predict_transfer(input logic act, input logic [31:0] seed);
    draw_result_t res;
    if (act == ACT_RESEED) begin
      seed_state(seed);
      twister_seeded = 1'b1;
      reseed_count++;
    end else begin
      draw_count++;
      if (!twister_seeded) begin
        res.value = '0;
        res.status = STAT_UNSEEDED;
        unseeded_count++;
      end else begin
        if (twister_pos >= STATE_DEPTH) twist_state();
        res.value = tempered_word(twister_words[twister_pos]);
        res.status = STAT_OK;
        twister_pos++;
      end
      expected_draws.push_back(res);
    end
  endfunction

  task automatic add_request(input logic act, input logic [31:0] seed);
    gen_request_t req;
    req.act = act;
    req.seed = seed;
    pending_requests.push_back(req);
  endtask

  task automatic report_failure(input string what);
    failures++;
    if (failures <= 10) $display("%0t ERROR: %s", $time, what);
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      action <= ACT_RESEED;
      seed_value <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_transfer(action, seed_value);
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 &&
            $urandom_range(99) >= send_idle_pct[idle_phase]) begin
          next_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          action <= next_req.act;
          seed_value <= next_req.seed;
          sent_items++;
          idle_phase <= (sent_items * 3) / (total_items + 1);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_draws.size() == 0) begin
          report_failure($sformatf("unexpected transfer value=%08h status=%0b",
                                   random_value, status));
        end else begin
          oldest_draw = expected_draws.pop_front();
          checked_count++;
          if (random_value !== oldest_draw.value)
            report_failure($sformatf("draw %0d random_value expected %08h got %08h",
                                     checked_count, oldest_draw.value, random_value));
          if (status !== oldest_draw.status)
            report_failure($sformatf("draw %0d status expected %0b got %0b",
                                     checked_count, oldest_draw.status, status));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct[idle_phase]);
    end
  end

  initial begin
    add_request(ACT_DRAW, 32'h0000_0000);
    add_request(ACT_DRAW, 32'hFFFF_FFFF);
    add_request(ACT_DRAW, $urandom());
    add_request(ACT_RESEED, 32'h0000_0000);
    repeat (3) add_request(ACT_DRAW, $urandom());
    add_request(ACT_RESEED, 32'hFFFF_FFFF);
    repeat (2) add_request(ACT_DRAW, 32'hFFFF_FFFF);
    add_request(ACT_RESEED, 32'd5489);
    repeat (3) add_request(ACT_DRAW, 32'h0000_0000);
    add_request(ACT_RESEED, 32'h8000_0000);
    repeat (2) add_request(ACT_DRAW, $urandom());
    add_request(ACT_RESEED, 32'h0000_1234);
    add_request(ACT_RESEED, 32'h7FFF_FFFF);
    add_request(ACT_DRAW, $urandom());
    add_request(ACT_RESEED, 32'h0000_0001);
    add_request(ACT_DRAW, $urandom());

    // One long run crosses the end of the store twice.
    add_request(ACT_RESEED, $urandom());
    repeat (1300) add_request(ACT_DRAW, $urandom());
    while (pending_requests.size() < 1850) begin
      if ($urandom_range(9) != 0) add_request(ACT_RESEED, $urandom());
      repeat ($urandom_range(40, 1)) add_request(ACT_DRAW, $urandom());
    end
    total_items = pending_requests.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_items < total_items) @(posedge clk);
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d requests: %0d reseeds and %0d draws, %0d of them before any seed.",
             total_items, reseed_count, draw_count, unseeded_count);
    $display("Checked %0d results across %0d state twists; %0d mismatches.",
             checked_count, twist_count, failures);
    if (failures == 0) begin
      $display("mt19937_generator_test: PASS");
    end else begin
      $display("mt19937_generator_test: FAIL");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Timed out with %0d of %0d requests accepted and %0d results outstanding.",
             accepted_items, total_items, expected_draws.size());
    $display("mt19937_generator_test: FAIL");
    $finish;
  end

endmodule
